// ===== hw/rtl/bdeq_pkg.sv =====
// Package with the shared constants of the button debounce event queue.
`default_nettype none

package bdeq_pkg;

  // Debounce threshold register: width, reset value and legal range.
  localparam int unsigned THR_W       = 7;
  localparam logic [6:0]  THR_RESET   = 7'd100;
  localparam logic [6:0]  THR_MIN     = 7'd1;
  localparam logic [6:0]  THR_MAX     = 7'd126;

  // Debounce counters are 8-bit signed and reset to "released", one step past
  // the negative reset threshold.
  localparam int unsigned CNT_W       = 8;
  localparam logic signed [7:0] CNT_RESET = -8'sd101;

  // Event codes and field widths.
  localparam int unsigned CODE_W      = 3;
  localparam logic [2:0]  EVT_NONE    = 3'd0;
  localparam int unsigned DROP_W      = 2;
  localparam int unsigned LEVELS_W    = 2;

endpackage

`default_nettype wire

// ===== hw/rtl/button_debounce_event_queue_unit.sv =====
// Two-button debouncer with signed counters and a ring FIFO of debounced events.
`default_nettype none

// Channel   Dir  Handshake               Payload
// --------  ---  ----------------------  ------------------------------------------
// s_axis    in   s_axis_tvalid/tready    tuser: mode; tdata: buttons_down
// m_axis    out  m_axis_tvalid/tready    tdata: event_code, dropped_events
// cfg       in   cfg_valid/cfg_ready     cfg_data: debounce_threshold
//
// A pop beat and a sample beat that queues no event go from acceptance through
// the in-flight stage into the output register. A beat with queued events waits
// there while its events go to the single-write-port memory or are dropped, one
// per cycle. A new beat is taken while the previous result still waits in the
// output register. Reset clears the counters to "released", empties the FIFO
// and loads a threshold of 100; the event memory itself is not cleared. The
// configuration channel is always ready.
module button_debounce_event_queue_unit #(
  parameter int unsigned FIFO_DEPTH   = 256,
  parameter int unsigned BUTTON_COUNT = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Sample/pop beats.
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // [1:0] buttons_down
  input  wire logic [0:0]                  s_axis_tuser_i,  // [0] mode
  // Results.
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,  // [2:0] event_code,
                                                            // [4:3] dropped_events
  // Threshold write channel.
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bdeq_pkg::THR_W-1:0]  cfg_data_i
);

  import bdeq_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // ---------------------------------------------------------------------
  // Threshold register, clamped to its legal range on use.
  // ---------------------------------------------------------------------
  logic [THR_W-1:0]        thr_q;
  logic signed [CNT_W-1:0] thr_pos;
  logic signed [CNT_W-1:0] thr_neg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_comb begin
    logic [THR_W-1:0] t;
    t = thr_q;
    if (t < THR_MIN) t = THR_MIN;
    if (t > THR_MAX) t = THR_MAX;
    thr_pos = signed'({1'b0, t});
    thr_neg = -thr_pos;
  end

  // ---------------------------------------------------------------------
  // Handshake and in-flight stage.
  // The stage holds one accepted beat until all of its events have been
  // written to the FIFO or dropped, then hands its result to the output register.
  // ---------------------------------------------------------------------
  logic                    in_fire;
  logic                    in_pop;
  logic [LEVELS_W-1:0]     in_levels;

  logic                    s1_valid_q;
  logic                    s1_hit_q;      // a pop that found an event
  logic [DROP_W-1:0]       s1_drop_q;
  logic [BUTTON_COUNT-1:0] s1_pend_q;     // buttons with an event still to queue
  logic [BUTTON_COUNT-1:0] s1_press_q;    // event kind per button: 1 pressed

  logic                    s1_adv;
  logic                    out_valid_q;
  logic [CODE_W-1:0]       out_code_q;
  logic [DROP_W-1:0]       out_drop_q;

  assign in_pop    = s_axis_tuser_i[0];
  assign in_levels = s_axis_tdata_i[LEVELS_W-1:0];

  assign s1_adv          = s1_valid_q && (s1_pend_q == '0) &&
                           (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------
  // FIFO pointers and memory.
  // ---------------------------------------------------------------------
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic              fifo_empty;
  logic              fifo_full;
  logic              pop_rd;
  logic [CODE_W-1:0] mem [FIFO_DEPTH];
  logic [CODE_W-1:0] rdata_q;

  assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
  assign fifo_empty = (wr_ptr_q == rd_ptr_q);
  assign fifo_full  = (wr_ptr_nxt == rd_ptr_q);
  assign pop_rd     = in_fire && in_pop && !fifo_empty;

  // Pick the lowest-numbered button with a pending event; one push a cycle.
  logic                    push_req;
  logic [BUTTON_COUNT-1:0] push_sel;
  logic [CODE_W-1:0]       push_code;
  logic                    push_we;

  always_comb begin
    push_req  = 1'b0;
    push_sel  = '0;
    push_code = EVT_NONE;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (s1_pend_q[i] && !push_req) begin
        push_req    = 1'b1;
        push_sel[i] = 1'b1;
        push_code   = s1_press_q[i] ? CODE_W'(2 * i + 1) : CODE_W'(2 * i + 2);
      end
    end
  end

  assign push_we = s1_valid_q && push_req && !fifo_full;

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem[wr_ptr_q] <= push_code;
    end
    if (pop_rd) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_we) wr_ptr_q <= wr_ptr_nxt;
      if (pop_rd)  rd_ptr_q <= rd_ptr_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Debounce counters, one lane per button. Buttons beyond the two input
  // levels always sample as up.
  // ---------------------------------------------------------------------
  logic signed [CNT_W-1:0] cnt_q [BUTTON_COUNT];
  logic signed [CNT_W-1:0] cnt_d [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] ev_hit;
  logic [BUTTON_COUNT-1:0] ev_press;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      logic down;
      down        = (i < LEVELS_W) ? in_levels[i % LEVELS_W] : 1'b0;
      cnt_d[i]    = cnt_q[i];
      ev_hit[i]   = 1'b0;
      ev_press[i] = down;
      if (down) begin
        if (cnt_q[i] <= 0) begin
          cnt_d[i] = 8'sd1;
        end else if (cnt_q[i] == thr_pos) begin
          cnt_d[i]  = cnt_q[i] + 8'sd1;
          ev_hit[i] = 1'b1;
        end else if (cnt_q[i] < thr_pos) begin
          cnt_d[i] = cnt_q[i] + 8'sd1;
        end
      end else begin
        if (cnt_q[i] >= 0) begin
          cnt_d[i] = -8'sd1;
        end else if (cnt_q[i] == thr_neg) begin
          cnt_d[i]  = cnt_q[i] - 8'sd1;
          ev_hit[i] = 1'b1;
        end else if (cnt_q[i] > thr_neg) begin
          cnt_d[i] = cnt_q[i] - 8'sd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) cnt_q[i] <= CNT_RESET;
    end else if (in_fire && !in_pop) begin
      for (int i = 0; i < BUTTON_COUNT; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  // ---------------------------------------------------------------------
  // In-flight stage registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pend_q  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_pend_q  <= in_pop ? '0 : ev_hit;
      end else begin
        if (s1_adv) s1_valid_q <= 1'b0;
        if (s1_valid_q && push_req) s1_pend_q <= s1_pend_q & ~push_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_hit_q   <= pop_rd;
      s1_drop_q  <= '0;
      s1_press_q <= ev_press;
    end else if (s1_valid_q && push_req && fifo_full) begin
      // The event is dropped; the count wraps in its two bits.
      s1_drop_q <= s1_drop_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_code_q <= s1_hit_q ? rdata_q : EVT_NONE;
      out_drop_q <= s1_drop_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_drop_q, out_code_q};

endmodule

`default_nettype wire
